// ===== hdl/nbmp_pkg.sv =====
// Shared types, constants and codes for the naive Bayes mutation posterior core.
`default_nettype none
package nbmp_pkg;

    // Likelihood, prior and posterior width (unsigned Q0.16)
    localparam int PB = 16;

    // Input field widths
    localparam int POS_W  = 9;
    localparam int LMER_W = 8;

    // Table depth defaults
    localparam int DEF_POSITION_DEPTH = 512;
    localparam int DEF_LMER_DEPTH     = 256;

    // Prior reset value: 0.5
    localparam logic [PB-1:0] PRIOR_RESET = 16'h8000;

    // Stream widths
    localparam int IN_TDATA_W  = 56;
    localparam int IN_TUSER_W  = 2;
    localparam int OUT_TDATA_W = 16;

    // Register file
    localparam int CFG_AW = 3;
    localparam int CFG_DW = 32;
    localparam logic REG_PRIOR_MUT   = 1'b0;
    localparam logic REG_PRIOR_MATCH = 1'b1;

    typedef enum logic [1:0] {
        MODE_QUERY   = 2'd0,
        MODE_WR_POS  = 2'd1,
        MODE_WR_LMER = 2'd2
    } t_mode;

    typedef struct packed {
        t_mode              mode;
        logic [POS_W-1:0]   position;
        logic [LMER_W-1:0]  lmer_index;
        logic               position_only;
        logic [PB-1:0]      mut_value;
        logic [PB-1:0]      match_value;
    } t_req;

    // Likelihoods of one query after the table read
    typedef struct packed {
        logic [PB-1:0] pos_mut;
        logic [PB-1:0] pos_match;
        logic [PB-1:0] lmer_mut;
        logic [PB-1:0] lmer_match;
        logic          position_only;
    } t_lik;

    // Class scores ready for the divider
    typedef struct packed {
        logic [2*PB-1:0] num;
        logic [2*PB:0]   den;
        logic            zero;
    } t_frac;

endpackage
`default_nettype wire

// ===== hdl/naive_bayes_mutation_posterior_core.sv =====
// Pipeline: an accepted query passes 1 table read, 4 score stages and 16 divider
// stages, one quotient bit each.
// Throughput: one request per cycle while s_axis_tready is high; table writes and queries
// interleave freely. Reset: priors return to 0.5, then a clearing pass zeroes both
// tables with s_axis_tready low; APB stays open.
`default_nettype none
module naive_bayes_mutation_posterior_core #(
    parameter int POSITION_DEPTH = nbmp_pkg::DEF_POSITION_DEPTH,
    parameter int LMER_DEPTH     = nbmp_pkg::DEF_LMER_DEPTH
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    // APB register port
    input  wire                                psel,
    input  wire                                penable,
    input  wire                                pwrite,
    input  wire  [nbmp_pkg::CFG_AW-1:0]        paddr,
    input  wire  [nbmp_pkg::CFG_DW-1:0]        pwdata,
    output logic [nbmp_pkg::CFG_DW-1:0]        prdata,
    output logic                               pready,
    // Request stream
    input  wire                                s_axis_tvalid,
    output logic                               s_axis_tready,
    // [8:0] position, [16:9] lmer_index, [17] position_only,
    // [33:18] mut_value, [49:34] match_value, [55:50] zero
    input  wire  [nbmp_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    // [1:0] mode
    input  wire  [nbmp_pkg::IN_TUSER_W-1:0]    s_axis_tuser,
    // Result stream
    output logic                               m_axis_tvalid,
    input  wire                                m_axis_tready,
    // [15:0] posterior
    output logic [nbmp_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
    // [0] undefined
    output logic                               m_axis_tuser
);

    localparam int PB = nbmp_pkg::PB;

    logic [PB-1:0]    r_prior_mut;
    logic [PB-1:0]    r_prior_match;
    logic             w_cfg_wr;

    nbmp_pkg::t_req   w_req;
    nbmp_pkg::t_lik   w_lik;
    nbmp_pkg::t_frac  w_frac;
    logic             w_lik_valid, w_lik_ready;
    logic             w_frac_valid, w_frac_ready;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prior_mut   <= nbmp_pkg::PRIOR_RESET;
            r_prior_match <= nbmp_pkg::PRIOR_RESET;
        end else if (w_cfg_wr) begin
            case (paddr[2])
                nbmp_pkg::REG_PRIOR_MUT:   r_prior_mut   <= pwdata[PB-1:0];
                nbmp_pkg::REG_PRIOR_MATCH: r_prior_match <= pwdata[PB-1:0];
                default: begin
                    r_prior_mut <= r_prior_mut;
                end
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            nbmp_pkg::REG_PRIOR_MUT:   prdata = nbmp_pkg::CFG_DW'(r_prior_mut);
            nbmp_pkg::REG_PRIOR_MATCH: prdata = nbmp_pkg::CFG_DW'(r_prior_match);
            default:                   prdata = '0;
        endcase
    end

    // Unpack the request
    assign w_req.mode          = nbmp_pkg::t_mode'(s_axis_tuser);
    assign w_req.position      = s_axis_tdata[8:0];
    assign w_req.lmer_index    = s_axis_tdata[16:9];
    assign w_req.position_only = s_axis_tdata[17];
    assign w_req.mut_value     = s_axis_tdata[33:18];
    assign w_req.match_value   = s_axis_tdata[49:34];

    nbmp_tables #(
        .POSITION_DEPTH (POSITION_DEPTH),
        .LMER_DEPTH     (LMER_DEPTH)
    ) u_tables (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .i_req   (w_req),
        .o_ready (s_axis_tready),
        .o_valid (w_lik_valid),
        .o_lik   (w_lik),
        .i_ready (w_lik_ready)
    );

    nbmp_score u_score (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_prior_mut   (r_prior_mut),
        .i_prior_match (r_prior_match),
        .i_valid       (w_lik_valid),
        .i_lik         (w_lik),
        .o_ready       (w_lik_ready),
        .o_valid       (w_frac_valid),
        .o_frac        (w_frac),
        .i_ready       (w_frac_ready)
    );

    nbmp_divider u_divider (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (w_frac_valid),
        .i_frac      (w_frac),
        .o_ready     (w_frac_ready),
        .o_valid     (m_axis_tvalid),
        .o_posterior (m_axis_tdata),
        .o_undefined (m_axis_tuser),
        .i_ready     (m_axis_tready)
    );

endmodule
`default_nettype wire

// ===== hdl/nbmp_tables.sv =====
// Likelihood tables: clearing pass, entry writes and registered query reads.
`default_nettype none
module nbmp_tables #(
    parameter int POSITION_DEPTH = nbmp_pkg::DEF_POSITION_DEPTH,
    parameter int LMER_DEPTH     = nbmp_pkg::DEF_LMER_DEPTH
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_valid,
    input  nbmp_pkg::t_req    i_req,
    output logic              o_ready,
    output logic              o_valid,
    output nbmp_pkg::t_lik    o_lik,
    input  wire               i_ready
);

    localparam int PB   = nbmp_pkg::PB;
    localparam int PA   = $clog2(POSITION_DEPTH);
    localparam int LA   = $clog2(LMER_DEPTH);
    localparam int PXW  = (PA > nbmp_pkg::POS_W) ? PA : nbmp_pkg::POS_W;
    localparam int LXW  = (LA > nbmp_pkg::LMER_W) ? LA : nbmp_pkg::LMER_W;
    localparam int MAXD = (POSITION_DEPTH > LMER_DEPTH) ? POSITION_DEPTH : LMER_DEPTH;
    localparam int CW   = $clog2(MAXD + 1);

    // Each row holds {match, mut}
    logic [2*PB-1:0] pos_mem  [POSITION_DEPTH];
    logic [2*PB-1:0] lmer_mem [LMER_DEPTH];

    logic            r_clearing;
    logic [CW-1:0]   r_clr_cnt;
    logic            r_v1;
    logic            r_pos_ok;
    logic            r_lmer_ok;
    logic            r_pos_only;
    logic [2*PB-1:0] r_pos_row;
    logic [2*PB-1:0] r_lmer_row;

    logic            w_load1;
    logic            w_accept;
    logic [PXW-1:0]  w_pos_ext;
    logic [LXW-1:0]  w_lmer_ext;
    logic [PA-1:0]   w_pos_addr;
    logic [LA-1:0]   w_lmer_addr;
    logic            w_pos_in;
    logic            w_lmer_in;
    logic            w_pos_we;
    logic            w_lmer_we;
    logic [PA-1:0]   w_pos_waddr;
    logic [LA-1:0]   w_lmer_waddr;
    logic [2*PB-1:0] w_wdata;
    logic            w_is_query;

    assign w_load1  = !r_v1 || i_ready;
    assign o_ready  = !r_clearing && w_load1;
    assign w_accept = i_valid && o_ready;

    assign w_pos_ext   = PXW'(i_req.position);
    assign w_lmer_ext  = LXW'(i_req.lmer_index);
    assign w_pos_addr  = w_pos_ext[PA-1:0];
    assign w_lmer_addr = w_lmer_ext[LA-1:0];
    assign w_pos_in    = 32'(i_req.position) < 32'(POSITION_DEPTH);
    assign w_lmer_in   = 32'(i_req.lmer_index) < 32'(LMER_DEPTH);

    always_comb begin
        w_pos_we   = 1'b0;
        w_lmer_we  = 1'b0;
        w_is_query = 1'b0;
        case (i_req.mode)
            nbmp_pkg::MODE_QUERY:   w_is_query = 1'b1;
            nbmp_pkg::MODE_WR_POS:  w_pos_we   = w_accept && w_pos_in;
            nbmp_pkg::MODE_WR_LMER: w_lmer_we  = w_accept && w_lmer_in;
            default: begin
                w_is_query = 1'b0;
            end
        endcase
        // Sweep zeros through both tables after reset
        if (r_clearing) begin
            w_pos_we  = 32'(r_clr_cnt) < 32'(POSITION_DEPTH);
            w_lmer_we = 32'(r_clr_cnt) < 32'(LMER_DEPTH);
        end
    end

    assign w_pos_waddr  = r_clearing ? r_clr_cnt[PA-1:0] : w_pos_addr;
    assign w_lmer_waddr = r_clearing ? r_clr_cnt[LA-1:0] : w_lmer_addr;
    assign w_wdata      = r_clearing ? '0 : {i_req.match_value, i_req.mut_value};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_cnt  <= '0;
        end else if (r_clearing) begin
            r_clr_cnt <= r_clr_cnt + CW'(1);
            if (r_clr_cnt == CW'(MAXD - 1)) begin
                r_clearing <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pos_we) begin
            pos_mem[w_pos_waddr] <= w_wdata;
        end
        if (w_load1) begin
            r_pos_row <= pos_mem[w_pos_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_lmer_we) begin
            lmer_mem[w_lmer_waddr] <= w_wdata;
        end
        if (w_load1) begin
            r_lmer_row <= lmer_mem[w_lmer_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (w_load1) begin
            r_v1 <= w_accept && w_is_query;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load1) begin
            r_pos_ok   <= w_pos_in;
            r_lmer_ok  <= w_lmer_in;
            r_pos_only <= i_req.position_only;
        end
    end

    // Out-of-range addresses read as zero likelihoods
    assign o_valid             = r_v1;
    assign o_lik.pos_mut       = r_pos_ok  ? r_pos_row[PB-1:0]     : '0;
    assign o_lik.pos_match     = r_pos_ok  ? r_pos_row[2*PB-1:PB]  : '0;
    assign o_lik.lmer_mut      = r_lmer_ok ? r_lmer_row[PB-1:0]    : '0;
    assign o_lik.lmer_match    = r_lmer_ok ? r_lmer_row[2*PB-1:PB] : '0;
    assign o_lik.position_only = r_pos_only;

endmodule
`default_nettype wire

// ===== hdl/nbmp_score.sv =====
// Class score pipeline: prior product, 4-mer scaling and denominator sum.
`default_nettype none
module nbmp_score (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire [nbmp_pkg::PB-1:0]     i_prior_mut,
    input  wire [nbmp_pkg::PB-1:0]     i_prior_match,
    input  wire                        i_valid,
    input  nbmp_pkg::t_lik             i_lik,
    output logic                       o_ready,
    output logic                       o_valid,
    output nbmp_pkg::t_frac            o_frac,
    input  wire                        i_ready
);

    localparam int PB = nbmp_pkg::PB;

    logic            r_v2, r_v3, r_v4, r_v5;
    logic            w_load2, w_load3, w_load4, w_load5;

    logic [2*PB-1:0] r_s2_smut, r_s2_smat;
    logic [PB-1:0]   r_s2_lmut, r_s2_lmat;
    logic            r_s2_use;

    logic [2*PB-1:0] r_s3_smut, r_s3_smat;
    logic [2*PB-1:0] r_s3_mut_hi, r_s3_mut_lo, r_s3_mat_hi, r_s3_mat_lo;
    logic            r_s3_use;

    logic [2*PB-1:0] r_s4_smut, r_s4_smat;

    logic [2*PB-1:0] r_s5_num;
    logic [2*PB:0]   r_s5_den;
    logic            r_s5_zero;

    assign w_load5 = !r_v5 || i_ready;
    assign w_load4 = !r_v4 || w_load5;
    assign w_load3 = !r_v3 || w_load4;
    assign w_load2 = !r_v2 || w_load3;
    assign o_ready = w_load2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else begin
            if (w_load2) r_v2 <= i_valid;
            if (w_load3) r_v3 <= r_v2;
            if (w_load4) r_v4 <= r_v3;
            if (w_load5) r_v5 <= r_v4;
        end
    end

    // Position likelihood times prior
    always_ff @(posedge i_clk) begin
        if (w_load2) begin
            r_s2_smut <= (2*PB)'(i_lik.pos_mut) * (2*PB)'(i_prior_mut);
            r_s2_smat <= (2*PB)'(i_lik.pos_match) * (2*PB)'(i_prior_match);
            r_s2_lmut <= i_lik.lmer_mut;
            r_s2_lmat <= i_lik.lmer_match;
            r_s2_use  <= !i_lik.position_only &&
                         ((i_lik.lmer_mut != '0) || (i_lik.lmer_match != '0));
        end
    end

    // Split each score into halves and multiply by the 4-mer likelihood
    always_ff @(posedge i_clk) begin
        if (w_load3) begin
            r_s3_smut   <= r_s2_smut;
            r_s3_smat   <= r_s2_smat;
            r_s3_mut_hi <= (2*PB)'(r_s2_smut[2*PB-1:PB]) * (2*PB)'(r_s2_lmut);
            r_s3_mut_lo <= (2*PB)'(r_s2_smut[PB-1:0]) * (2*PB)'(r_s2_lmut);
            r_s3_mat_hi <= (2*PB)'(r_s2_smat[2*PB-1:PB]) * (2*PB)'(r_s2_lmat);
            r_s3_mat_lo <= (2*PB)'(r_s2_smat[PB-1:0]) * (2*PB)'(r_s2_lmat);
            r_s3_use    <= r_s2_use;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load4) begin
            r_s4_smut <= r_s3_use ? (r_s3_mut_hi + (r_s3_mut_lo >> PB)) : r_s3_smut;
            r_s4_smat <= r_s3_use ? (r_s3_mat_hi + (r_s3_mat_lo >> PB)) : r_s3_smat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load5) begin
            r_s5_num  <= r_s4_smut;
            r_s5_den  <= {1'b0, r_s4_smut} + {1'b0, r_s4_smat};
            r_s5_zero <= (r_s4_smut == '0) && (r_s4_smat == '0);
        end
    end

    assign o_valid     = r_v5;
    assign o_frac.num  = r_s5_num;
    assign o_frac.den  = r_s5_den;
    assign o_frac.zero = r_s5_zero;

endmodule
`default_nettype wire

// ===== hdl/nbmp_divider.sv =====
// Pipelined restoring divider: one quotient bit per stage, num <= den.
`default_nettype none
module nbmp_divider (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire                        i_valid,
    input  nbmp_pkg::t_frac            i_frac,
    output logic                       o_ready,
    output logic                       o_valid,
    output logic [nbmp_pkg::PB-1:0]    o_posterior,
    output logic                       o_undefined,
    input  wire                        i_ready
);

    localparam int PB = nbmp_pkg::PB;
    localparam int RW = 2 * PB + 1;

    logic          r_v    [PB];
    logic [RW-1:0] r_rem  [PB];
    logic [PB-1:0] r_quo  [PB];
    logic [RW-1:0] r_den  [PB];
    logic          r_zero [PB];

    logic          w_load     [PB+1];
    logic          w_src_v    [PB];
    logic [RW-1:0] w_src_rem  [PB];
    logic [PB-1:0] w_src_quo  [PB];
    logic [RW-1:0] w_src_den  [PB];
    logic          w_src_zero [PB];

    assign w_load[PB] = i_ready;
    assign o_ready    = w_load[0];

    for (genvar k = 0; k < PB; k++) begin : g_stage
        logic [RW:0] w_trial;
        logic        w_bit;

        if (k == 0) begin : g_first
            assign w_src_v[k]    = i_valid;
            assign w_src_rem[k]  = {1'b0, i_frac.num};
            assign w_src_quo[k]  = '0;
            assign w_src_den[k]  = i_frac.den;
            assign w_src_zero[k] = i_frac.zero;
        end else begin : g_next
            assign w_src_v[k]    = r_v[k-1];
            assign w_src_rem[k]  = r_rem[k-1];
            assign w_src_quo[k]  = r_quo[k-1];
            assign w_src_den[k]  = r_den[k-1];
            assign w_src_zero[k] = r_zero[k-1];
        end

        assign w_load[k] = !r_v[k] || w_load[k+1];
        assign w_trial   = {w_src_rem[k], 1'b0};
        assign w_bit     = w_trial >= {1'b0, w_src_den[k]};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (w_load[k]) begin
                r_v[k] <= w_src_v[k];
            end
        end

        // Subtract when the shifted remainder covers the divisor
        always_ff @(posedge i_clk) begin
            if (w_load[k]) begin
                r_rem[k]  <= w_bit ? RW'(w_trial - {1'b0, w_src_den[k]}) : RW'(w_trial);
                r_quo[k]  <= {w_src_quo[k][PB-2:0], w_bit};
                r_den[k]  <= w_src_den[k];
                r_zero[k] <= w_src_zero[k];
            end
        end
    end

    // Zero denominator forces the posterior to 0
    assign o_valid     = r_v[PB-1];
    assign o_posterior = r_zero[PB-1] ? '0 : r_quo[PB-1];
    assign o_undefined = r_zero[PB-1];

endmodule
`default_nettype wire
